// File: design/chained_hash_table_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash table
// Shared wrappers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_INSERT_DELETE_DEFINES_SVH
`define CHAINED_HASH_TABLE_INSERT_DELETE_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define CHT_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define CHT_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (prop)) \
    else $error(msg);

`endif

// File: design/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Types and codes shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_LOAD,
    S_WALK_RD,
    S_WALK_CHK,
    S_REM_RD,
    S_REM_CHK,
    S_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;        // capture the request, start the bucket reduction
    logic    mod_step;    // fold one key digit into the remainder
    logic    load_cur;    // cursor to bucket head, previous to null
    logic    alloc;       // take a free node and write key into it
    logic    head_fresh;  // point the bucket head at the fresh node
    logic    adv;         // previous to cursor, cursor to its link
    logic    tail_link;   // link the chain tail to the fresh node
    logic    rem_hit;     // unlink the cursor node and free it
    logic    set_st;      // record the result code
    status_e st;
    logic    publish;     // move the result code into the output register
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  mod_last;
    logic  head_nil;
    logic  full;
    logic  link_nil;
    logic  hit;
    logic  out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/cht_if.sv
// ----------------------------------------------------------------------------
// Chained hash table channels
// Request and response valid/ready channels with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface cht_req_if;
  import cht_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cht_rsp_if;
  import cht_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

// File: design/chained_hash_table_insert_delete.sv
// ----------------------------------------------------------------------------
// Chained hash table with insert and remove
// Separate-chaining table over a bounded node pool, one status per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one transaction per operation: kind (insert or remove) and a
//   31-bit key. rsp_o returns exactly one 2-bit status per request, in order:
//   inserted, deleted, not found or pool full.
//   The key is reduced to its bucket eight bits per cycle, then the chain is
//   walked node by node through the registered read port of the node memory.
//   One operation at a time: a new request is taken once the previous one has
//   handed its status to the output register.
//   Reset: every bucket reads empty and every node is free; no clearing pass
//   is needed, since head validity sits in flip-flops and nodes are handed out
//   from an allocation mark and a free stack.
//   Stall: a status not yet taken holds in the output register; the next
//   request is still accepted and worked on, and its status waits until the
//   register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_insert_delete
  import cht_pkg::*;
#(
  parameter int BUCKETS      = 7,
  parameter int POOL_ENTRIES = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cht_req_if.sink     req_i,
  cht_rsp_if.source   rsp_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Controller: walks the operation through its steps
  cht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: bucket reduction, memories, cursors and output register
  cht_datapath #(
    .BUCKETS      (BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_kind_i   (req_i.kind),
    .req_value_i  (req_i.value),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status)
  );

endmodule

`default_nettype wire

// File: design/cht_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/cht_datapath.sv
// ----------------------------------------------------------------------------
// Chained hash table datapath
// Bucket reduction, head/node/free-stack memories, cursors and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_table_insert_delete_defines.svh"

module cht_datapath
  import cht_pkg::*;
#(
  parameter int BUCKETS      = 7,
  parameter int POOL_ENTRIES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctl_cmd_t            cmd_i,
  output dp_stat_t                 stat_o,
  input  wire logic                req_kind_i,
  input  wire logic [VALUE_W-1:0]  req_value_i,
  input  wire logic                rsp_ready_i,
  output logic                     rsp_valid_o,
  output logic      [STATUS_W-1:0] rsp_status_o
);

  localparam int NW     = $clog2(POOL_ENTRIES + 1);
  localparam int AW     = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int BW     = $clog2(BUCKETS);
  localparam int DIG_W  = 8;
  localparam int DIGITS = (VALUE_W + DIG_W - 1) / DIG_W;
  localparam int PAD_W  = DIGITS * DIG_W;
  localparam int CW     = $clog2(DIGITS);
  localparam int TW     = BW + DIG_W;
  localparam int SH     = TW + BW;
  localparam int MW     = TW + 2;
  localparam logic [NW-1:0] NIL    = NW'(POOL_ENTRIES);
  localparam logic [MW-1:0] RECIP  = MW'(((1 << SH) + BUCKETS - 1) / BUCKETS);
  localparam logic [CW-1:0] LASTB  = CW'(DIGITS - 1);

  logic               kind_q;
  logic [VALUE_W-1:0] key_q;
  logic [PAD_W-1:0]   shift_q;
  logic [CW-1:0]      cnt_q;
  logic [BW-1:0]      rem_q;
  logic [NW-1:0]      cur_q;
  logic [NW-1:0]      prev_q;
  logic [AW-1:0]      fresh_q;
  logic [NW-1:0]      sc_q;
  logic [NW-1:0]      hw_q;
  logic [BUCKETS-1:0] hv_q;
  status_e            st_q;
  logic               out_valid_q;
  status_e            out_status_q;

  logic [TW-1:0]      trial;
  logic [TW+MW-1:0]   prod;
  logic [TW-1:0]      quo;
  logic [TW-1:0]      rem_full;
  logic [BW-1:0]      rem_d;
  logic [NW-1:0]      bkt_rdata;
  logic [NW-1:0]      head;
  logic [NW-1:0]      link_rdata;
  logic [VALUE_W-1:0] val_rdata;
  logic [AW-1:0]      stk_rdata;
  logic [NW-1:0]      sc_dec;
  logic               stack_empty;
  logic               pool_full;
  logic [AW-1:0]      fresh;
  logic               prev_nil;

  logic               link_we;
  logic [AW-1:0]      link_waddr;
  logic [NW-1:0]      link_wdata;
  logic               bkt_we;
  logic [NW-1:0]      bkt_wdata;

  // Remainder by the bucket count, one key digit per step; the quotient of
  // the small partial value comes from an exact reciprocal multiplication
  assign trial    = {rem_q, shift_q[PAD_W-1 -: DIG_W]};
  assign prod     = (TW+MW)'(trial) * (TW+MW)'(RECIP);
  assign quo      = TW'(prod >> SH);
  assign rem_full = trial - TW'(quo * TW'(BUCKETS));
  assign rem_d    = rem_full[BW-1:0];

  assign head        = hv_q[rem_q] ? bkt_rdata : NIL;
  assign sc_dec      = sc_q - NW'(1);
  assign stack_empty = (sc_q == '0);
  assign pool_full   = stack_empty && (hw_q == NIL);
  assign fresh       = stack_empty ? hw_q[AW-1:0] : stk_rdata;
  assign prev_nil    = (prev_q == NIL);

  always_comb begin
    link_we    = 1'b0;
    link_waddr = fresh;
    link_wdata = NIL;
    if (cmd_i.alloc) begin
      link_we = 1'b1;
    end else if (cmd_i.tail_link) begin
      link_we    = 1'b1;
      link_waddr = cur_q[AW-1:0];
      link_wdata = NW'(fresh_q);
    end else if (cmd_i.rem_hit && !prev_nil) begin
      link_we    = 1'b1;
      link_waddr = prev_q[AW-1:0];
      link_wdata = link_rdata;
    end
  end

  assign bkt_we    = cmd_i.head_fresh || (cmd_i.rem_hit && prev_nil);
  assign bkt_wdata = cmd_i.head_fresh ? NW'(fresh) : link_rdata;

  cht_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (rem_q),
    .wdata_i (bkt_wdata),
    .raddr_i (rem_q),
    .rdata_o (bkt_rdata)
  );

  cht_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_ENTRIES)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.alloc),
    .waddr_i (fresh),
    .wdata_i (key_q),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (val_rdata)
  );

  cht_ram #(.WIDTH(NW), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (link_rdata)
  );

  cht_ram #(.WIDTH(AW), .DEPTH(POOL_ENTRIES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rem_hit),
    .waddr_i (sc_q[AW-1:0]),
    .wdata_i (cur_q[AW-1:0]),
    .raddr_i (sc_dec[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_kind_i;
      key_q   <= req_value_i;
      shift_q <= PAD_W'(req_value_i);
      cnt_q   <= '0;
      rem_q   <= '0;
    end else if (cmd_i.mod_step) begin
      shift_q <= shift_q << DIG_W;
      cnt_q   <= cnt_q + CW'(1);
      rem_q   <= rem_d;
    end
    if (cmd_i.load_cur) begin
      cur_q  <= head;
      prev_q <= NIL;
    end else if (cmd_i.adv) begin
      prev_q <= cur_q;
      cur_q  <= link_rdata;
    end
    if (cmd_i.alloc) begin
      fresh_q <= fresh;
    end
    if (cmd_i.set_st) begin
      st_q <= cmd_i.st;
    end
    if (cmd_i.publish) begin
      out_status_q <= st_q;
    end
  end

  // Pool bookkeeping and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= '0;
      hw_q        <= '0;
      hv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.alloc) begin
        if (stack_empty) begin
          hw_q <= hw_q + NW'(1);
        end else begin
          sc_q <= sc_dec;
        end
      end else if (cmd_i.rem_hit) begin
        sc_q <= sc_q + NW'(1);
      end
      if (cmd_i.head_fresh) begin
        hv_q[rem_q] <= 1'b1;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.kind     = kind_e'(kind_q);
  assign stat_o.mod_last = (cnt_q == LASTB);
  assign stat_o.head_nil = (head == NIL);
  assign stat_o.full     = pool_full;
  assign stat_o.link_nil = (link_rdata == NIL);
  assign stat_o.hit      = (val_rdata == key_q);
  assign stat_o.out_busy = out_valid_q && !rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;

  `CHT_ASSERT_AT(a_stack_le_mark, clk_i, rst_ni, (sc_q <= hw_q) && (hw_q <= NIL), "free stack exceeds allocation mark")
  `CHT_ASSERT_AT(a_no_alloc_full, clk_i, rst_ni, !(cmd_i.alloc && pool_full), "node taken from a full pool")
  `CHT_ASSERT_AT(a_hit_node_used, clk_i, rst_ni, !cmd_i.rem_hit || (sc_q != hw_q), "node freed with no node in use")
  `CHT_ASSERT_NEXT(a_publish_shows, clk_i, rst_ni, cmd_i.publish, rsp_valid_o && (rsp_status_o == $past(st_q)), "result not presented")

endmodule

`default_nettype wire

// File: design/cht_ctrl.sv
// ----------------------------------------------------------------------------
// Chained hash table controller
// Sequences reduction, head fetch, chain walk and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cht_ctrl
  import cht_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire dp_stat_t stat_i,
  output ctl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_MOD;
      end
      S_MOD: begin
        if (stat_i.mod_last) state_d = S_HEAD;
      end
      S_HEAD: state_d = S_LOAD;
      S_LOAD: begin
        if (stat_i.kind == KIND_INSERT) begin
          if (stat_i.full || stat_i.head_nil) state_d = S_FINISH;
          else state_d = S_WALK_RD;
        end else begin
          if (stat_i.head_nil) state_d = S_FINISH;
          else state_d = S_REM_RD;
        end
      end
      S_WALK_RD: state_d = S_WALK_CHK;
      S_WALK_CHK: begin
        if (stat_i.link_nil) state_d = S_FINISH;
        else state_d = S_WALK_RD;
      end
      S_REM_RD: state_d = S_REM_CHK;
      S_REM_CHK: begin
        if (stat_i.hit || stat_i.link_nil) state_d = S_FINISH;
        else state_d = S_REM_RD;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.st    = ST_INSERTED;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_MOD: cmd_o.mod_step = 1'b1;
      S_HEAD: ;
      S_LOAD: begin
        cmd_o.load_cur = 1'b1;
        if (stat_i.kind == KIND_INSERT) begin
          if (stat_i.full) begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_FULL;
          end else begin
            cmd_o.alloc = 1'b1;
            if (stat_i.head_nil) begin
              cmd_o.head_fresh = 1'b1;
              cmd_o.set_st     = 1'b1;
              cmd_o.st         = ST_INSERTED;
            end
          end
        end else if (stat_i.head_nil) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOT_FOUND;
        end
      end
      S_WALK_RD: ;
      S_WALK_CHK: begin
        if (stat_i.link_nil) begin
          cmd_o.tail_link = 1'b1;
          cmd_o.set_st    = 1'b1;
          cmd_o.st        = ST_INSERTED;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_REM_RD: ;
      S_REM_CHK: begin
        if (stat_i.hit) begin
          cmd_o.rem_hit = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st      = ST_DELETED;
        end else if (stat_i.link_nil) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_NOT_FOUND;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_FINISH: cmd_o.publish = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
